// ----- rtl/core/lprm_pkg.sv -----
`default_nettype none

package lprm_pkg;

    // Default sizes of the cache.
    localparam int unsigned DEVICE_SLOTS_DEF      = 16;
    localparam int unsigned MODEL_PAGE_COUNT_DEF  = 64;
    localparam int unsigned ELEMENTS_PER_PAGE_DEF = 2048;

    // Field widths of the stream items.
    localparam int unsigned PAGE_INDEX_W    = 6;
    localparam int unsigned ELEMENT_INDEX_W = 11;
    localparam int unsigned SLOT_FIELD_W    = 4;
    localparam int unsigned ADDR_FIELD_W    = 15;
    localparam int unsigned VICTIM_FIELD_W  = 6;
    localparam int unsigned TOTAL_W         = 32;
    localparam int unsigned STAMP_W         = 64;

    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 96;
    localparam int unsigned M_TUSER_W = 2;

    // Bit positions inside the streams.
    localparam int unsigned IN_PAGE_LSB  = 0;
    localparam int unsigned IN_ELEM_LSB  = IN_PAGE_LSB + PAGE_INDEX_W;
    localparam int unsigned OUT_SLOT_LSB = 0;
    localparam int unsigned OUT_ADDR_LSB = OUT_SLOT_LSB + SLOT_FIELD_W;
    localparam int unsigned OUT_VICT_LSB = OUT_ADDR_LSB + ADDR_FIELD_W;
    localparam int unsigned OUT_FLT_LSB  = OUT_VICT_LSB + VICTIM_FIELD_W;
    localparam int unsigned OUT_EVC_LSB  = OUT_FLT_LSB + TOTAL_W;
    localparam int unsigned OUT_USED_W   = OUT_EVC_LSB + TOTAL_W;
    localparam int unsigned USER_HIT     = 0;
    localparam int unsigned USER_EVICTED = 1;

    localparam int unsigned MOD_STEPS = 6;

    // Remainder of a narrow value by a constant through a short chain of
    // conditional subtractions of the shifted divisor.
    function automatic logic [15:0] mod_small(input logic [15:0] value,
                                              input int unsigned divisor);
        logic [31:0] rem;
        logic [31:0] shifted;
        rem = 32'(value);
        for (int k = MOD_STEPS - 1; k >= 0; k--)
        begin
            shifted = 32'(divisor) << k;
            if (shifted <= rem)
            begin
                rem = rem - shifted;
            end
        end
        return rem[15:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/lru_page_residency_manager.sv -----
`default_nettype none

// Fully associative LRU page cache. Each input transfer is one element read
// of a model page; each yields exactly one result transfer with hit, slot,
// device word address, eviction and running counts. After reset the block
// clears every entry of its page table before it takes the first item.
// Items are processed one at a time: a hit passes through the check and
// done states, a fault into a free slot through check, install and done,
// and a fault that must evict through check, a scan of the stamp memory at
// one entry per cycle, owner, evict, install and done. A finished result
// sits in the output register; the next item is accepted while it waits.
module lru_page_residency_manager
    import lprm_pkg::*;
#(
    parameter int unsigned DEVICE_SLOTS      = DEVICE_SLOTS_DEF,
    parameter int unsigned MODEL_PAGE_COUNT  = MODEL_PAGE_COUNT_DEF,
    parameter int unsigned ELEMENTS_PER_PAGE = ELEMENTS_PER_PAGE_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // page_index [5:0], element_index [16:6], zero fill above
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // device_slot [3:0], device_word_address [18:4], victim_page [24:19],
    // fault_total [56:25], evict_total [88:57], zero fill above
    output logic [M_TDATA_W-1:0]      m_tdata,
    // hit [0], evicted [1]
    output logic [M_TUSER_W-1:0]      m_tuser
);

    localparam int unsigned SLOT_W = $clog2(DEVICE_SLOTS);
    localparam int unsigned PAGE_W = $clog2(MODEL_PAGE_COUNT);
    localparam int unsigned CNT_W  = $clog2(DEVICE_SLOTS + 1);
    localparam int unsigned ENT_W  = SLOT_W + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_OWNER,
        S_EVICT,
        S_INSTALL,
        S_DONE
    } state_t;

    state_t                state_reg;
    logic [PAGE_W-1:0]     clr_idx_reg;
    logic [PAGE_W-1:0]     page_reg;
    logic [ELEMENT_INDEX_W-1:0] elem_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic                  hit_reg;
    logic                  evicted_reg;
    logic [PAGE_W-1:0]     victim_reg;
    logic [CNT_W-1:0]      fill_cnt_reg;
    logic [CNT_W-1:0]      scan_idx_reg;
    logic [SLOT_W-1:0]     best_slot_reg;
    logic [STAMP_W-1:0]    best_stamp_reg;
    logic [STAMP_W-1:0]    tick_reg;
    logic [TOTAL_W-1:0]    fault_cnt_reg;
    logic [TOTAL_W-1:0]    evict_cnt_reg;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic [M_TUSER_W-1:0]  m_tuser_reg;

    // Page table: valid bit and slot per page.
    logic [ENT_W-1:0]      page_mem [MODEL_PAGE_COUNT];
    logic [ENT_W-1:0]      page_rdata_reg;
    logic [PAGE_W-1:0]     page_raddr;
    logic                  page_we;
    logic [PAGE_W-1:0]     page_waddr;
    logic [ENT_W-1:0]      page_wdata;

    // Slot owner and slot stamp memories.
    logic [PAGE_W-1:0]     owner_mem [DEVICE_SLOTS];
    logic [PAGE_W-1:0]     owner_rdata_reg;
    logic                  owner_we;
    logic [STAMP_W-1:0]    stamp_mem [DEVICE_SLOTS];
    logic [STAMP_W-1:0]    stamp_rdata_reg;
    logic [SLOT_W-1:0]     stamp_raddr;
    logic                  stamp_we;
    logic [SLOT_W-1:0]     stamp_waddr;
    logic [STAMP_W-1:0]    stamp_wdata;

    logic [15:0]           in_page_mod;
    logic [15:0]           in_elem_mod;
    logic [PAGE_W-1:0]     in_page;
    logic                  in_fire;
    logic                  entry_valid;
    logic [SLOT_W-1:0]     entry_slot;
    logic [SLOT_W-1:0]     scan_slot;
    logic [31:0]           addr_wide;
    logic [31:0]           slot_wide;
    logic [31:0]           victim_wide;
    logic [M_TDATA_W-1:0]  result_data;

    assign in_page_mod = mod_small(16'(s_tdata[IN_PAGE_LSB +: PAGE_INDEX_W]),
                                   MODEL_PAGE_COUNT);
    assign in_elem_mod = mod_small(16'(s_tdata[IN_ELEM_LSB +: ELEMENT_INDEX_W]),
                                   ELEMENTS_PER_PAGE);
    assign in_page     = in_page_mod[PAGE_W-1:0];

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign entry_valid = page_rdata_reg[SLOT_W];
    assign entry_slot  = page_rdata_reg[SLOT_W-1:0];
    // Stamp data in the scan belongs to the slot addressed in the cycle before.
    assign scan_slot   = SLOT_W'(scan_idx_reg - CNT_W'(1));

    assign page_raddr  = (state_reg == S_IDLE) ? in_page : page_reg;
    assign stamp_raddr = scan_idx_reg[SLOT_W-1:0];

    assign addr_wide   = 32'(slot_reg) * 32'(ELEMENTS_PER_PAGE) + 32'(elem_reg);
    assign slot_wide   = 32'(slot_reg);
    assign victim_wide = 32'(victim_reg);

    always_comb
    begin
        result_data = '0;
        result_data[OUT_SLOT_LSB +: SLOT_FIELD_W]   = slot_wide[SLOT_FIELD_W-1:0];
        result_data[OUT_ADDR_LSB +: ADDR_FIELD_W]   = addr_wide[ADDR_FIELD_W-1:0];
        result_data[OUT_VICT_LSB +: VICTIM_FIELD_W] = victim_wide[VICTIM_FIELD_W-1:0];
        result_data[OUT_FLT_LSB +: TOTAL_W]         = fault_cnt_reg;
        result_data[OUT_EVC_LSB +: TOTAL_W]         = evict_cnt_reg;
    end

    always_comb
    begin
        page_we     = 1'b0;
        page_waddr  = page_reg;
        page_wdata  = '0;
        owner_we    = 1'b0;
        stamp_we    = 1'b0;
        stamp_waddr = slot_reg;
        stamp_wdata = tick_reg;
        case (state_reg)
            S_CLEAR:
            begin
                page_we    = 1'b1;
                page_waddr = clr_idx_reg;
            end
            S_CHECK:
            begin
                if (entry_valid)
                begin
                    stamp_we    = 1'b1;
                    stamp_waddr = entry_slot;
                end
            end
            S_EVICT:
            begin
                page_we    = 1'b1;
                page_waddr = owner_rdata_reg;
            end
            S_INSTALL:
            begin
                // The fill stamp is overwritten at once by the access stamp.
                page_we     = 1'b1;
                page_wdata  = {1'b1, slot_reg};
                owner_we    = 1'b1;
                stamp_we    = 1'b1;
                stamp_wdata = tick_reg + STAMP_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (page_we)
        begin
            page_mem[page_waddr] <= page_wdata;
        end
        page_rdata_reg <= page_mem[page_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (owner_we)
        begin
            owner_mem[slot_reg] <= page_reg;
        end
        owner_rdata_reg <= owner_mem[best_slot_reg];
    end

    always_ff @(posedge clk)
    begin
        if (stamp_we)
        begin
            stamp_mem[stamp_waddr] <= stamp_wdata;
        end
        stamp_rdata_reg <= stamp_mem[stamp_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            fill_cnt_reg  <= '0;
            scan_idx_reg  <= '0;
            tick_reg      <= '0;
            fault_cnt_reg <= '0;
            evict_cnt_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && state_reg != S_DONE)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + PAGE_W'(1);
                    if (clr_idx_reg == PAGE_W'(MODEL_PAGE_COUNT - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        page_reg    <= in_page;
                        elem_reg    <= in_elem_mod[ELEMENT_INDEX_W-1:0];
                        evicted_reg <= 1'b0;
                        victim_reg  <= '0;
                        state_reg   <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (entry_valid)
                    begin
                        hit_reg   <= 1'b1;
                        slot_reg  <= entry_slot;
                        tick_reg  <= tick_reg + STAMP_W'(1);
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        hit_reg       <= 1'b0;
                        fault_cnt_reg <= fault_cnt_reg + TOTAL_W'(1);
                        if (fill_cnt_reg != CNT_W'(DEVICE_SLOTS))
                        begin
                            slot_reg     <= fill_cnt_reg[SLOT_W-1:0];
                            fill_cnt_reg <= fill_cnt_reg + CNT_W'(1);
                            state_reg    <= S_INSTALL;
                        end
                        else
                        begin
                            scan_idx_reg <= '0;
                            state_reg    <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                    if (scan_idx_reg != '0)
                    begin
                        // Strict compare keeps the lowest slot on equal stamps.
                        if (scan_idx_reg == CNT_W'(1) || stamp_rdata_reg < best_stamp_reg)
                        begin
                            best_stamp_reg <= stamp_rdata_reg;
                            best_slot_reg  <= scan_slot;
                        end
                        if (scan_idx_reg == CNT_W'(DEVICE_SLOTS))
                        begin
                            state_reg <= S_OWNER;
                        end
                    end
                end
                S_OWNER:
                begin
                    state_reg <= S_EVICT;
                end
                S_EVICT:
                begin
                    evicted_reg   <= 1'b1;
                    victim_reg    <= owner_rdata_reg;
                    slot_reg      <= best_slot_reg;
                    evict_cnt_reg <= evict_cnt_reg + TOTAL_W'(1);
                    state_reg     <= S_INSTALL;
                end
                S_INSTALL:
                begin
                    tick_reg  <= tick_reg + STAMP_W'(2);
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= result_data;
                        m_tuser_reg  <= {evicted_reg, hit_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/lprm_checker.sv -----
`default_nettype none

module lprm_checker
    import lprm_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [M_TUSER_W-1:0] m_tuser
);

    // A stalled result must hold still until its transfer completes.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Items are taken one at a time, so ready drops right after a transfer.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[USER_HIT] |-> !m_tuser[USER_EVICTED])
        else $error("hit reported together with an eviction");

    a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[USER_EVICTED]
            |-> m_tdata[OUT_VICT_LSB +: VICTIM_FIELD_W] == '0)
        else $error("victim page set without an eviction");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_TDATA_W-1:OUT_USED_W] == '0)
        else $error("result padding bits not zero");

endmodule

bind lru_page_residency_manager lprm_checker u_lprm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- sim/lru_page_residency_manager_test.sv -----
`default_nettype none

module lru_page_residency_manager_test;
    import lprm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned N_SLOTS          = DEVICE_SLOTS_DEF;
    localparam int unsigned N_PAGES          = MODEL_PAGE_COUNT_DEF;
    localparam int          N_DIRECTED       = 22;
    localparam int          N_PHASES         = 4;
    localparam int          RANDOM_PER_PHASE = 110;
    localparam int          HOT_PAGES        = 20;
    localparam int          SETTLE_CYCLES    = 2 * (DEVICE_SLOTS_DEF + 6);
    localparam int          STALL_LIMIT      = 2000;

    typedef struct packed {
        logic                      hit;
        logic [SLOT_FIELD_W-1:0]   slot;
        logic [ADDR_FIELD_W-1:0]   addr;
        logic                      evicted;
        logic [VICTIM_FIELD_W-1:0] victim;
        logic [TOTAL_W-1:0]        fault_total;
        logic [TOTAL_W-1:0]        evict_total;
    } access_result_t;

    typedef struct packed {
        logic [PAGE_INDEX_W-1:0]    page;
        logic [ELEMENT_INDEX_W-1:0] elem;
        logic                       typed;
        access_result_t             want;
    } access_row_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // Mirror of the cache state.
    logic                      slot_used     [N_SLOTS];
    logic [PAGE_INDEX_W-1:0]   slot_page     [N_SLOTS];
    logic [STAMP_W-1:0]        slot_age      [N_SLOTS];
    logic                      page_resident [N_PAGES];
    logic [SLOT_FIELD_W-1:0]   page_slot     [N_PAGES];
    logic [STAMP_W-1:0]        lru_tick      = '0;
    logic [TOTAL_W-1:0]        fault_count   = '0;
    logic [TOTAL_W-1:0]        evict_count   = '0;

    access_result_t pending_results [$];
    int             mismatches    = 0;
    int             stall_pct     = 0;
    int             quiet_cycles  = 0;

    access_row_t directed_rows [N_DIRECTED] = '{
        '{6'd0,  11'd0,    1'b1, '{1'b0, 4'd0, 15'd0,    1'b0, 6'd0,  32'd1,  32'd0}},
        '{6'd63, 11'd2047, 1'b1, '{1'b0, 4'd1, 15'd4095, 1'b0, 6'd0,  32'd2,  32'd0}},
        '{6'd0,  11'd2047, 1'b1, '{1'b1, 4'd0, 15'd2047, 1'b0, 6'd0,  32'd2,  32'd0}},
        '{6'd1,  11'd1,    1'b0, '0},
        '{6'd2,  11'd2,    1'b0, '0},
        '{6'd3,  11'd4,    1'b0, '0},
        '{6'd4,  11'd8,    1'b0, '0},
        '{6'd5,  11'd16,   1'b0, '0},
        '{6'd6,  11'd32,   1'b0, '0},
        '{6'd7,  11'd64,   1'b0, '0},
        '{6'd8,  11'd128,  1'b0, '0},
        '{6'd9,  11'd256,  1'b0, '0},
        '{6'd10, 11'd512,  1'b0, '0},
        '{6'd11, 11'd1024, 1'b0, '0},
        '{6'd12, 11'h555,  1'b0, '0},
        '{6'd13, 11'h2AA,  1'b0, '0},
        '{6'd14, 11'd2047, 1'b0, '0},
        // All slots are full now; the page in slot 1 has the oldest stamp.
        '{6'd32, 11'h555,  1'b1, '{1'b0, 4'd1, 15'd3413, 1'b1, 6'd63, 32'd17, 32'd1}},
        '{6'd63, 11'h2AA,  1'b0, '0},
        '{6'd32, 11'd0,    1'b0, '0},
        '{6'd0,  11'd2047, 1'b0, '0},
        '{6'd14, 11'd0,    1'b0, '0}
    };

    lru_page_residency_manager DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    // One page read: fill from the lowest free slot or evict the oldest stamp,
    // then restamp the slot that now holds the page.
    function automatic access_result_t lru_access(input logic [PAGE_INDEX_W-1:0] page,
                                                  input logic [ELEMENT_INDEX_W-1:0] elem);
        access_result_t res;
        int             fill_slot;
        logic [SLOT_FIELD_W-1:0] slot;
        res = '0;
        res.hit = 1'b1;
        if (!page_resident[page])
        begin
            res.hit = 1'b0;
            fault_count++;
            fill_slot = -1;
            for (int s = N_SLOTS - 1; s >= 0; s--)
            begin
                if (!slot_used[s])
                begin
                    fill_slot = s;
                end
            end
            if (fill_slot < 0)
            begin
                fill_slot = 0;
                for (int s = 1; s < N_SLOTS; s++)
                begin
                    if (slot_age[s] < slot_age[fill_slot])
                    begin
                        fill_slot = s;
                    end
                end
                page_resident[slot_page[fill_slot]] = 1'b0;
                res.evicted = 1'b1;
                res.victim = slot_page[fill_slot];
                evict_count++;
            end
            slot_used[fill_slot] = 1'b1;
            slot_page[fill_slot] = page;
            page_resident[page] = 1'b1;
            page_slot[page] = SLOT_FIELD_W'(fill_slot);
            slot_age[fill_slot] = lru_tick;
            lru_tick++;
        end
        slot = page_slot[page];
        slot_age[slot] = lru_tick;
        lru_tick++;
        res.slot = slot;
        res.addr = ADDR_FIELD_W'(slot * ELEMENTS_PER_PAGE_DEF + elem);
        res.fault_total = fault_count;
        res.evict_total = evict_count;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_access(input logic [PAGE_INDEX_W-1:0] page,
                               input logic [ELEMENT_INDEX_W-1:0] elem,
                               input int idle_pct, input logic typed,
                               input access_result_t want);
        logic [S_TDATA_W-1:0] word;
        access_result_t       predicted;
        int                   gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        word = '0;
        word[IN_PAGE_LSB +: PAGE_INDEX_W] = page;
        word[IN_ELEM_LSB +: ELEMENT_INDEX_W] = elem;
        s_tvalid <= 1'b1;
        s_tdata <= word;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predicted = lru_access(page, elem);
        pending_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        access_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no access pending");
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("hit", want.hit, m_tuser[USER_HIT]);
                check_field("device_slot", want.slot, m_tdata[OUT_SLOT_LSB +: SLOT_FIELD_W]);
                check_field("device_word_address", want.addr,
                            m_tdata[OUT_ADDR_LSB +: ADDR_FIELD_W]);
                check_field("evicted", want.evicted, m_tuser[USER_EVICTED]);
                check_field("victim_page", want.victim,
                            m_tdata[OUT_VICT_LSB +: VICTIM_FIELD_W]);
                check_field("fault_total", want.fault_total, m_tdata[OUT_FLT_LSB +: TOTAL_W]);
                check_field("evict_total", want.evict_total, m_tdata[OUT_EVC_LSB +: TOTAL_W]);
            end
        end
    end

    // Watchdog: counts cycles in which neither side completes a transfer.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("** lru_page_residency_manager: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int send_idle [N_PHASES];
        int recv_stall [N_PHASES];
        logic [PAGE_INDEX_W-1:0] page;
        logic [PAGE_INDEX_W-1:0] last_page;
        logic [PAGE_INDEX_W-1:0] hot_base;
        int roll;
        send_idle = '{0, 69, 0, 15};
        recv_stall = '{0, 0, 69, 15};
        last_page = '0;
        for (int s = 0; s < N_SLOTS; s++)
        begin
            slot_used[s] = 1'b0;
            slot_page[s] = '0;
            slot_age[s] = '0;
        end
        for (int p = 0; p < N_PAGES; p++)
        begin
            page_resident[p] = 1'b0;
            page_slot[p] = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < N_DIRECTED; r++)
        begin
            send_access(directed_rows[r].page, directed_rows[r].elem, 0,
                        directed_rows[r].typed, directed_rows[r].want);
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            stall_pct = recv_stall[ph];
            hot_base = PAGE_INDEX_W'($urandom_range(N_PAGES - 1));
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                // A working set a little larger than the cache keeps both hits
                // and evictions frequent; the rest spreads over every page.
                roll = $urandom_range(99);
                if (roll < 15)
                begin
                    page = last_page;
                end
                else if (roll < 70)
                begin
                    page = hot_base + PAGE_INDEX_W'($urandom_range(HOT_PAGES - 1));
                end
                else
                begin
                    page = PAGE_INDEX_W'($urandom_range(N_PAGES - 1));
                end
                last_page = page;
                send_access(page, ELEMENT_INDEX_W'($urandom_range(ELEMENTS_PER_PAGE_DEF - 1)),
                            send_idle[ph], 1'b0, '0);
            end
            // Hold the sender off until the block has handed back every result.
            s_tvalid <= 1'b0;
            while (pending_results.size() != 0)
            begin
                @(posedge clk);
            end
            @(negedge clk);
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("** lru_page_residency_manager: PASSED **");
        end
        else
        begin
            $display("** lru_page_residency_manager: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
